/* design/ipacl_pkg.sv */
// Shared types, codes and helpers for the first-match IPv4 prefix access list.
package ipacl_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W      = 32;
   localparam int PREFIX_W    = 6;
   localparam int FULL_PREFIX = 32;

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      FAM_UNRESOLVED = 2'd0,
      FAM_IPV4       = 2'd1,
      FAM_IPV6       = 2'd2,
      FAM_OTHER      = 2'd3
   } family_type;

   typedef enum logic [1:0] {
      OUT_NO_MATCH = 2'd0,
      OUT_FAIL     = 2'd1,
      OUT_MATCH    = 2'd2,
      OUT_NEG      = 2'd3
   } outcome_type;

   typedef struct packed {
      family_type              family;
      logic                    negate;
      logic                    group;
      logic [PREFIX_W-1:0]     prefix;
      logic [ADDR_W-1:0]       address;
   } entry_type;

   typedef struct packed {
      logic        decide;
      outcome_type outcome;
   } verdict_type;

   // Zero and anything at or above a full prefix compare every bit
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] prefix);
      logic [ADDR_W-1:0] mask;
      if (prefix == '0 || prefix >= PREFIX_W'(FULL_PREFIX)) begin
         mask = '1;
      end else begin
         mask = ~({ADDR_W{1'b1}} >> prefix);
      end
      return mask;
   endfunction

endpackage

/* design/ipacl_rule_ram.sv */
// Rule table storage: one write port, one registered read port.
module ipacl_rule_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ipacl_pkg::IDX_W-1:0]   wr_addr,
   input  ipacl_pkg::entry_type          wr_data,
   input  logic [ipacl_pkg::IDX_W-1:0]   rd_addr,
   output ipacl_pkg::entry_type          rd_data
);

   ipacl_pkg::entry_type mem [ipacl_pkg::TABLE_DEPTH];
   ipacl_pkg::entry_type rd_data_ff;

   // Write on enable
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ipacl_rule_eval.sv */
// Shared rule evaluator: decides one table entry against the client.
module ipacl_rule_eval (
   input  ipacl_pkg::entry_type           entry,
   input  ipacl_pkg::family_type          client_family,
   input  logic [ipacl_pkg::ADDR_W-1:0]   client_address,
   output ipacl_pkg::verdict_type         verdict
);

   logic [ipacl_pkg::ADDR_W-1:0] mask;
   logic                         addr_hit;

   // Prefix compare
   assign mask     = ipacl_pkg::prefix_mask(entry.prefix);
   assign addr_hit = ((client_address ^ entry.address) & mask) == '0;

   // Classify the entry
   always_comb begin
      verdict.decide  = 1'b0;
      verdict.outcome = ipacl_pkg::OUT_NEG;
      case (entry.family)
         ipacl_pkg::FAM_UNRESOLVED: begin
            verdict.decide  = entry.negate && !entry.group;
            verdict.outcome = ipacl_pkg::OUT_FAIL;
         end
         ipacl_pkg::FAM_IPV4: begin
            verdict.decide  = (client_family == ipacl_pkg::FAM_IPV4) && addr_hit;
            verdict.outcome = entry.negate ? ipacl_pkg::OUT_NEG : ipacl_pkg::OUT_MATCH;
         end
         default: begin
            verdict.decide  = (client_family == entry.family) && entry.negate;
            verdict.outcome = ipacl_pkg::OUT_NEG;
         end
      endcase
   end

endmodule

/* design/ipv4_prefix_acl_first_match.sv */
// A lookup ends at its first deciding entry, or after scanning rule_count entries (at most TABLE_DEPTH).
// Throughput: one entry per cycle through the single rule evaluator fed by the table's read port.
// A write transfer gives no result; after a lookup, the next item waits until its result enters the output register.
// Reset clears the sequencer, the result valid and rule_count; the rule table is not cleared.
// A finished result waits in the output register while the next item may transfer.
// A stalled result holds the lookup that finishes behind it in the done state until the output register frees.
module ipv4_prefix_acl_first_match (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [ipacl_pkg::CNT_W-1:0]     csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_mode,
   input  logic [ipacl_pkg::IDX_W-1:0]     req_entry_index,
   input  logic [1:0]                      req_entry_family,
   input  logic                            req_entry_negate,
   input  logic                            req_entry_group,
   input  logic [ipacl_pkg::PREFIX_W-1:0]  req_entry_prefix,
   input  logic [ipacl_pkg::ADDR_W-1:0]    req_entry_address,
   input  logic [1:0]                      req_client_family,
   input  logic [ipacl_pkg::ADDR_W-1:0]    req_client_address,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_allowed,
   output logic [1:0]                      rsp_outcome,
   output logic [ipacl_pkg::CNT_W-1:0]     rsp_rule_index
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   localparam logic [ipacl_pkg::CNT_W-1:0] DEPTH_CNT = ipacl_pkg::CNT_W'(ipacl_pkg::TABLE_DEPTH);

   state_type                           state_ff, state_in;
   logic [ipacl_pkg::CNT_W-1:0]         csr_count_ff, csr_count_in;
   logic [ipacl_pkg::CNT_W-1:0]         scan_count_ff, scan_count_in;
   logic [ipacl_pkg::CNT_W-1:0]         issue_idx_ff, issue_idx_in;
   logic                                pend_vld_ff, pend_vld_in;
   logic [ipacl_pkg::IDX_W-1:0]         pend_idx_ff, pend_idx_in;
   ipacl_pkg::family_type               client_fam_ff, client_fam_in;
   logic [ipacl_pkg::ADDR_W-1:0]        client_addr_ff, client_addr_in;
   ipacl_pkg::outcome_type              res_outcome_ff, res_outcome_in;
   logic [ipacl_pkg::CNT_W-1:0]         res_idx_ff, res_idx_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   ipacl_pkg::outcome_type              rsp_outcome_ff, rsp_outcome_in;
   logic [ipacl_pkg::CNT_W-1:0]         rsp_idx_ff, rsp_idx_in;

   logic                                req_xfer;
   logic                                ram_wr_en;
   ipacl_pkg::entry_type                ram_wr_data;
   ipacl_pkg::entry_type                ram_rd_data;
   ipacl_pkg::verdict_type              verdict;
   logic                                issue_more;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign ram_wr_en = req_xfer && (req_mode == ipacl_pkg::MODE_WRITE);

   assign ram_wr_data.family  = ipacl_pkg::family_type'(req_entry_family);
   assign ram_wr_data.negate  = req_entry_negate;
   assign ram_wr_data.group   = req_entry_group;
   assign ram_wr_data.prefix  = req_entry_prefix;
   assign ram_wr_data.address = req_entry_address;

   ipacl_rule_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_entry_index),
      .wr_data (ram_wr_data),
      .rd_addr (issue_idx_ff[ipacl_pkg::IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   ipacl_rule_eval u_eval (
      .entry          (ram_rd_data),
      .client_family  (client_fam_ff),
      .client_address (client_addr_ff),
      .verdict        (verdict)
   );

   assign issue_more = issue_idx_ff < scan_count_ff;

   // Sequencer: accept, scan entries in order, hand the result to the output register
   always_comb begin
      state_in       = state_ff;
      csr_count_in   = csr_count_ff;
      scan_count_in  = scan_count_ff;
      issue_idx_in   = issue_idx_ff;
      pend_vld_in    = pend_vld_ff;
      pend_idx_in    = pend_idx_ff;
      client_fam_in  = client_fam_ff;
      client_addr_in = client_addr_ff;
      res_outcome_in = res_outcome_ff;
      res_idx_in     = res_idx_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_idx_in     = rsp_idx_ff;

      if (csr_write_en) begin
         csr_count_in = csr_write_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_mode == ipacl_pkg::MODE_LOOKUP)) begin
               client_fam_in  = ipacl_pkg::family_type'(req_client_family);
               client_addr_in = req_client_address;
               scan_count_in  = (csr_count_ff > DEPTH_CNT) ? DEPTH_CNT : csr_count_ff;
               issue_idx_in   = '0;
               pend_vld_in    = 1'b0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pend_vld_ff && verdict.decide) begin
               // first deciding entry ends the scan
               res_outcome_in = verdict.outcome;
               res_idx_in     = {1'b0, pend_idx_ff};
               pend_vld_in    = 1'b0;
               state_in       = ST_DONE;
            end else if (!pend_vld_ff && !issue_more) begin
               res_outcome_in = ipacl_pkg::OUT_NO_MATCH;
               res_idx_in     = scan_count_ff;
               state_in       = ST_DONE;
            end else if (issue_more) begin
               pend_vld_in  = 1'b1;
               pend_idx_in  = issue_idx_ff[ipacl_pkg::IDX_W-1:0];
               issue_idx_in = issue_idx_ff + ipacl_pkg::CNT_W'(1);
            end else begin
               pend_vld_in = 1'b0;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = res_outcome_ff;
               rsp_idx_in     = res_idx_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_count_ff <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_count_ff <= csr_count_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      scan_count_ff  <= scan_count_in;
      issue_idx_ff   <= issue_idx_in;
      pend_idx_ff    <= pend_idx_in;
      client_fam_ff  <= client_fam_in;
      client_addr_ff <= client_addr_in;
      res_outcome_ff <= res_outcome_in;
      res_idx_ff     <= res_idx_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_idx_ff     <= rsp_idx_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_outcome    = rsp_outcome_ff;
   assign rsp_allowed    = (rsp_outcome_ff == ipacl_pkg::OUT_MATCH);
   assign rsp_rule_index = rsp_idx_ff;

`ifndef SYNTHESIS
   // A pending read always lies inside the scanned range
   assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> ({1'b0, pend_idx_ff} < scan_count_ff))
      else $error("pending entry outside scan range");

   // The scan only runs while the input side is held off
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (req_stall && !ram_wr_en))
      else $error("table write during scan");

   // A no-match result reports the full scanned count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && res_outcome_ff == ipacl_pkg::OUT_NO_MATCH)
         |-> (res_idx_ff == scan_count_ff))
      else $error("no-match index differs from scanned count");

   // A loaded result is never lost to a waiting one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_idx_ff)))
      else $error("stalled result dropped");
`endif

endmodule

/* tb/sv/ipv4_prefix_acl_first_match_tb.sv */
// Self-checking testbench for the first-match IPv4 prefix access list.
module ipv4_prefix_acl_first_match_tb;
   import ipacl_pkg::*;

   localparam int SETTLE_CYCLES   = TABLE_DEPTH + 8;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int COUNT_MAX       = (1 << CNT_W) - 1;
   localparam int PHASES          = 3;
   localparam int SEGMENTS        = 8;
   localparam int SEGMENT_ITEMS   = 80;
   localparam int MAX_REPORTS     = 100;

   typedef struct packed {
      logic                mode;
      logic [IDX_W-1:0]    entry_index;
      family_type          entry_family;
      logic                entry_negate;
      logic                entry_group;
      logic [PREFIX_W-1:0] entry_prefix;
      logic [ADDR_W-1:0]   entry_address;
      family_type          client_family;
      logic [ADDR_W-1:0]   client_address;
   } acl_item_t;

   localparam int ITEM_W = $bits(acl_item_t);

   typedef struct packed {
      logic             allowed;
      outcome_type      outcome;
      logic [CNT_W-1:0] rule_index;
   } verdict_t;

   // Shadow rule table and the verdicts still owed by the block
   class acl_verdict_ledger;
      entry_type   rules [TABLE_DEPTH];
      int unsigned rule_count;
      verdict_t    pending_verdicts [$];
      int          errors;
      int          reports;
      int          tally [4];

      function new();
         rule_count = 0;
         errors     = 0;
         reports    = 0;
         foreach (tally[k]) tally[k] = 0;
      endfunction

      function logic [ADDR_W-1:0] compare_mask(logic [PREFIX_W-1:0] len);
         logic [ADDR_W-1:0] ones;
         ones = '1;
         if (len == 0 || len >= FULL_PREFIX) return ones;
         return ones << (ADDR_W - int'(len));
      endfunction

      // Scan entries in order; the first deciding entry wins
      function verdict_t classify_client(family_type fam, logic [ADDR_W-1:0] addr);
         verdict_t v;
         int       span;
         bit       decided;
         span = (rule_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(rule_count);
         v.outcome    = OUT_NO_MATCH;
         v.rule_index = CNT_W'(span);
         decided      = 1'b0;
         for (int i = 0; i < span && !decided; i++) begin
            if (rules[i].family == FAM_UNRESOLVED) begin
               if (rules[i].negate && !rules[i].group) begin
                  v.outcome = OUT_FAIL;
                  decided   = 1'b1;
               end
            end else if (rules[i].family == fam) begin
               if (rules[i].family == FAM_IPV4) begin
                  if (((addr ^ rules[i].address) & compare_mask(rules[i].prefix)) == '0) begin
                     v.outcome = rules[i].negate ? OUT_NEG : OUT_MATCH;
                     decided   = 1'b1;
                  end
               end else if (rules[i].negate) begin
                  v.outcome = OUT_NEG;
                  decided   = 1'b1;
               end
            end
            if (decided) v.rule_index = CNT_W'(i);
         end
         v.allowed = (v.outcome == OUT_MATCH);
         return v;
      endfunction

      // Store a rule, or queue the verdict a lookup must produce
      function void note_transfer(acl_item_t it);
         if (it.mode == MODE_WRITE) begin
            rules[it.entry_index].family  = it.entry_family;
            rules[it.entry_index].negate  = it.entry_negate;
            rules[it.entry_index].group   = it.entry_group;
            rules[it.entry_index].prefix  = it.entry_prefix;
            rules[it.entry_index].address = it.entry_address;
         end else begin
            pending_verdicts.push_back(classify_client(it.client_family, it.client_address));
         end
      endfunction

      function void report_mismatch(string field, logic [31:0] want, logic [31:0] got);
         errors++;
         if (reports < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         reports++;
      endfunction

      function void check_verdict(logic allowed, logic [1:0] outcome, logic [CNT_W-1:0] idx);
         verdict_t want;
         if (pending_verdicts.size() == 0) begin
            errors++;
            if (reports < MAX_REPORTS)
               $display("%0t: unexpected result, expected none, actual outcome %0d index %0d",
                        $time, outcome, idx);
            reports++;
            return;
         end
         want = pending_verdicts.pop_front();
         tally[want.outcome]++;
         if (allowed !== want.allowed) report_mismatch("allowed", want.allowed, allowed);
         if (outcome !== want.outcome) report_mismatch("outcome", want.outcome, outcome);
         if (idx !== want.rule_index) report_mismatch("rule_index", want.rule_index, idx);
      endfunction
   endclass

   logic                clock;
   logic                reset              = 1'b1;
   logic                csr_write_en       = 1'b0;
   logic [CNT_W-1:0]    csr_write_data     = '0;
   logic                req_valid          = 1'b0;
   logic                req_stall;
   logic                req_mode           = MODE_WRITE;
   logic [IDX_W-1:0]    req_entry_index    = '0;
   logic [1:0]          req_entry_family   = '0;
   logic                req_entry_negate   = 1'b0;
   logic                req_entry_group    = 1'b0;
   logic [PREFIX_W-1:0] req_entry_prefix   = '0;
   logic [ADDR_W-1:0]   req_entry_address  = '0;
   logic [1:0]          req_client_family  = '0;
   logic [ADDR_W-1:0]   req_client_address = '0;
   logic                rsp_valid;
   logic                rsp_stall          = 1'b0;
   logic                rsp_allowed;
   logic [1:0]          rsp_outcome;
   logic [CNT_W-1:0]    rsp_rule_index;

   acl_verdict_ledger ledger;
   bit                written_mask [TABLE_DEPTH];
   int                send_idle_pct  = 0;
   int                recv_stall_pct = 0;
   int                quiet_cycles   = 0;
   int                writes_sent    = 0;
   int                lookups_sent   = 0;
   int                counts_set     = 0;

   ipv4_prefix_acl_first_match u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_entry_index    (req_entry_index),
      .req_entry_family   (req_entry_family),
      .req_entry_negate   (req_entry_negate),
      .req_entry_group    (req_entry_group),
      .req_entry_prefix   (req_entry_prefix),
      .req_entry_address  (req_entry_address),
      .req_client_family  (req_client_family),
      .req_client_address (req_client_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_allowed        (rsp_allowed),
      .rsp_outcome        (rsp_outcome),
      .rsp_rule_index     (rsp_rule_index)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Check every result transfer against the oldest verdict
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         ledger.check_verdict(rsp_allowed, rsp_outcome, rsp_rule_index);
   end

   // Count cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("%0t: no transfer for %0d cycles, %0d verdicts outstanding",
               $time, WATCHDOG_LIMIT, ledger.pending_verdicts.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Number of entries written without a hole, counted from entry zero
   function automatic int written_span();
      int span;
      span = 0;
      while (span < TABLE_DEPTH && written_mask[span]) span++;
      return span;
   endfunction

   function automatic acl_item_t rule_item(int idx, family_type fam, bit neg, bit grp,
                                           int len, logic [ADDR_W-1:0] addr);
      acl_item_t it;
      it               = '0;
      it.mode          = MODE_WRITE;
      it.entry_index   = IDX_W'(idx);
      it.entry_family  = fam;
      it.entry_negate  = neg;
      it.entry_group   = grp;
      it.entry_prefix  = PREFIX_W'(len);
      it.entry_address = addr;
      return it;
   endfunction

   function automatic acl_item_t lookup_item(family_type fam, logic [ADDR_W-1:0] addr);
      acl_item_t it;
      it                = '0;
      it.mode           = MODE_LOOKUP;
      it.client_family  = fam;
      it.client_address = addr;
      return it;
   endfunction

   // Present one item after a random gap and hold it until the transfer
   task automatic send_item(input acl_item_t it);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= it.mode;
      req_entry_index    <= it.entry_index;
      req_entry_family   <= it.entry_family;
      req_entry_negate   <= it.entry_negate;
      req_entry_group    <= it.entry_group;
      req_entry_prefix   <= it.entry_prefix;
      req_entry_address  <= it.entry_address;
      req_client_family  <= it.client_family;
      req_client_address <= it.client_address;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ledger.note_transfer(it);
      if (it.mode == MODE_WRITE) begin
         written_mask[it.entry_index] = 1'b1;
         writes_sent++;
      end else begin
         lookups_sent++;
      end
   endtask

   // Hold off until every verdict is in and the scan has surely ended
   task automatic settle();
      req_valid <= 1'b0;
      while (ledger.pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_count(input int value);
      csr_write_en   <= 1'b1;
      csr_write_data <= CNT_W'(value);
      @(posedge clock);
      ledger.rule_count = value;
      csr_write_en <= 1'b0;
      counts_set++;
   endtask

   initial begin
      acl_item_t                   it;
      logic [ITEM_W-1:0]           noise;
      entry_type                   target;
      logic [ADDR_W-1:0]           wild;
      int                          span;
      int                          count;
      int                          pick;
      int                          k;

      ledger = new();
      foreach (written_mask[i]) written_mask[i] = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty list after reset
      send_item(lookup_item(FAM_IPV4, 32'h0000_0000));

      // Rules covering each scan case: skipped unresolved, other families,
      // zero and oversized prefixes, negated entries and a failing entry
      send_item(rule_item(0, FAM_UNRESOLVED, 1, 1, 0, 32'h0000_0000));
      send_item(rule_item(1, FAM_UNRESOLVED, 0, 0, 5, 32'h1234_5678));
      send_item(rule_item(2, FAM_IPV6, 0, 0, 16, 32'hffff_ffff));
      send_item(rule_item(3, FAM_IPV4, 0, 0, 0, 32'hc0a8_0101));
      send_item(rule_item(4, FAM_IPV4, 1, 0, 63, 32'hffff_ffff));
      send_item(rule_item(5, FAM_IPV4, 0, 1, 8, 32'h0a00_0000));
      send_item(rule_item(6, FAM_IPV4, 1, 1, 1, 32'h8000_0000));
      send_item(rule_item(7, FAM_OTHER, 1, 0, 32, 32'h0000_0001));
      send_item(rule_item(8, FAM_IPV6, 1, 0, 33, 32'h0000_0000));
      send_item(rule_item(9, FAM_IPV4, 0, 0, 32, 32'h0000_0000));
      send_item(rule_item(10, FAM_UNRESOLVED, 1, 0, 0, 32'h0000_0000));
      send_item(rule_item(11, FAM_IPV4, 0, 0, 31, 32'h0000_0000));
      send_item(rule_item(TABLE_DEPTH - 1, FAM_OTHER, 1, 1, 63, 32'hffff_ffff));
      settle();
      program_count(12);
      send_item(lookup_item(FAM_IPV4, 32'hc0a8_0101));
      send_item(lookup_item(FAM_IPV4, 32'hffff_ffff));
      send_item(lookup_item(FAM_IPV4, 32'hffff_fffe));
      send_item(lookup_item(FAM_IPV4, 32'h0a12_3456));
      send_item(lookup_item(FAM_IPV4, 32'h0000_0000));
      send_item(lookup_item(FAM_IPV4, 32'h7fff_ffff));
      send_item(lookup_item(FAM_IPV6, 32'h0000_0000));
      send_item(lookup_item(FAM_OTHER, 32'hffff_ffff));
      send_item(lookup_item(FAM_UNRESOLVED, 32'h0000_0000));

      // Random traffic: idling per phase, none in every fourth segment; a rule_count per segment
      for (int phase = 0; phase < PHASES; phase++) begin
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (phase == PHASES - 1 || seg % 4 == 3) begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end else if (phase == 0) begin
               send_idle_pct  = 12;
               recv_stall_pct = 83;
            end else begin
               send_idle_pct  = 83;
               recv_stall_pct = 12;
            end
            settle();
            span = written_span();
            case (seg)
               0: count = span;
               1: count = 0;
               2: count = (span == TABLE_DEPTH) ? COUNT_MAX : span;
               3: count = (span == TABLE_DEPTH) ?
                          $urandom_range(COUNT_MAX - 1, TABLE_DEPTH + 1) : span;
               default: count = ($urandom_range(3) == 0) ? span : $urandom_range(span);
            endcase
            program_count(count);
            repeat (SEGMENT_ITEMS) begin
               noise = ITEM_W'({$urandom, $urandom, $urandom});
               it    = acl_item_t'(noise);
               span  = written_span();
               if ($urandom_range(99) < 40) begin
                  // Half the time extend the run of entries from entry zero, else write anywhere
                  it.mode = MODE_WRITE;
                  if (span < TABLE_DEPTH && $urandom_range(1) == 1) begin
                     it.entry_index = IDX_W'(span);
                  end else begin
                     it.entry_index = IDX_W'($urandom_range(TABLE_DEPTH - 1));
                  end
                  pick = $urandom_range(99);
                  it.entry_family = (pick < 8)  ? FAM_UNRESOLVED :
                                    (pick < 70) ? FAM_IPV4 :
                                    (pick < 85) ? FAM_IPV6 : FAM_OTHER;
                  it.entry_negate = ($urandom_range(3) == 0);
                  it.entry_group  = ($urandom_range(9) < 3);
                  if ($urandom_range(7) == 0) begin
                     it.entry_prefix = PREFIX_W'($urandom_range(63));
                  end else begin
                     it.entry_prefix = PREFIX_W'($urandom_range(FULL_PREFIX));
                  end
                  // Cluster half the addresses so rules overlap
                  if ($urandom_range(1) == 1)
                     it.entry_address = {8'h0a, 14'd0, 2'($urandom_range(3)), 8'($urandom)};
               end else begin
                  it.mode = MODE_LOOKUP;
                  if (span > 0 && $urandom_range(9) < 7) begin
                     // Aim at a stored rule, mostly varying only bits outside its prefix
                     k      = $urandom_range(span - 1);
                     target = ledger.rules[k];
                     wild   = $urandom;
                     if ($urandom_range(3) != 0) wild = wild & ~ledger.compare_mask(target.prefix);
                     it.client_address = target.address ^ wild;
                     it.client_family  = (target.family == FAM_UNRESOLVED) ?
                                         FAM_IPV4 : target.family;
                  end else begin
                     it.client_family = family_type'($urandom_range(3));
                  end
               end
               send_item(it);
            end
         end
      end

      settle();
      $display("Sent %0d rule writes and %0d lookups across %0d rule_count settings.",
               writes_sent, lookups_sent, counts_set);
      $display("Verdicts seen: %0d no match, %0d unresolved fail, %0d match, %0d negative.",
               ledger.tally[OUT_NO_MATCH], ledger.tally[OUT_FAIL],
               ledger.tally[OUT_MATCH], ledger.tally[OUT_NEG]);
      if (ledger.pending_verdicts.size() != 0) begin
         $display("%0t: %0d verdicts never arrived", $time, ledger.pending_verdicts.size());
         ledger.errors++;
      end
      if (ledger.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/ipacl_pkg.sv
design/ipacl_rule_ram.sv
design/ipacl_rule_eval.sv
design/ipv4_prefix_acl_first_match.sv
tb/sv/ipv4_prefix_acl_first_match_tb.sv
